### hw/rtl/b10k_pkg.sv
// ----------------------------------------------------------------------------
// b10k_pkg - shared types and constants of the base-10000 limb unit
// widths, action codes, sequencer states and the divider request/response
// ----------------------------------------------------------------------------
`default_nettype none

package b10k_pkg;

  localparam int LIMB_W    = 14;              // one base-10000 limb
  localparam int RUN_W     = 15;              // carry, borrow, remainder or divisor
  localparam int WIDE_W    = LIMB_W + RUN_W;  // partial dividend or product
  localparam int STEPS_W   = 4;               // step counters
  localparam int DIV_STEPS = RUN_W;           // quotient bits per division
  localparam int MUL_STEPS = LIMB_W;          // multiplier bits per product

  localparam logic [LIMB_W-1:0] LIMB_MAX  = 14'd9999;
  localparam logic [RUN_W-1:0]  LIMB_BASE = 15'd10000;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_DIV = 2'd2,
    ACT_MUL = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALU,
    S_RED_GO,
    S_RED_WAIT,
    S_SCALE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_MDIV_GO,
    S_MDIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] dividend;
    logic [RUN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RUN_W-1:0] quotient;
    logic [RUN_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/base10000_limb_alu.sv
// ----------------------------------------------------------------------------
// base10000_limb_alu - one limb step of base-10000 multiprecision arithmetic
// add with carry, subtract with borrow, divide and multiply by a small integer
// ----------------------------------------------------------------------------
// usage
//   input stream (s_*): one limb per transaction; tuser carries the action
//   (add, subtract, divide, multiply) and a first-limb flag, which clears the
//   running carry, borrow or remainder before it is used.
//   limbs go least significant first, for divide most significant first.
//   output stream (m_*): exactly one result transaction per input transaction
//   with the result limb, the running value after the limb and a fault flag.
//   steps from input transaction to result valid:
//     add / subtract : the add or subtract step, then the done state
//     divide         : scale and one divider pass, after a reduction pass when
//                      the held remainder is not below the divisor; straight to done on divide by zero
//     multiply       : the shift-add multiplier, then a divider pass by 10000
//   the shared bit-serial divider and the shift-add multiplier set the length
//   of these steps; one item is in flight at a time and the next is taken once
//   the sequencer is back in idle after its result is registered.
//   the result sits in an output register, so a new input transaction is
//   taken while the previous result waits; with the receiver stalled the
//   block finishes the item and then holds until the output register drains.
//   synchronous reset clears the running value, the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module base10000_limb_alu
  import b10k_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [13:0] limb_a, [28:14] operand_b, [31:29] zero
  input  logic [2:0]  s_tuser,   // [1:0] action, [2] first_limb
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [13:0] result_limb, [28:14] running_value, [31:29] zero
  output logic [0:0]  m_tuser    // [0] fault
);

  // sequencer
  state_t state;
  state_t state_next;

  // item registers
  action_t             act;
  logic [LIMB_W-1:0]   a_lim;       // limb_a, clamped to 9999
  logic [RUN_W-1:0]    b_raw;       // operand_b as received
  logic [RUN_W-1:0]    run_w;       // working running value
  logic [LIMB_W-1:0]   res_w;
  logic                fault_w;

  // shift-add multiplier, acc doubles as the scaled dividend for division
  logic [WIDE_W-1:0]   acc;
  logic [WIDE_W-1:0]   mcand;
  logic [LIMB_W-1:0]   mplier;
  logic [STEPS_W-1:0]  cnt;

  logic [RUN_W-1:0]    carry_register;

  // output register
  logic [LIMB_W-1:0]   out_res;
  logic [RUN_W-1:0]    out_run;
  logic                out_fault;

  // divider
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // input decode
  action_t             in_act;
  logic [LIMB_W-1:0]   in_a;
  logic [RUN_W-1:0]    in_b;
  logic [LIMB_W-1:0]   in_a_lim;
  logic                in_a_over;
  logic                in_b_over;
  logic [RUN_W-1:0]    in_run;
  logic                accept;
  logic                out_free;

  // add / subtract datapath
  logic [LIMB_W-1:0]   b_lim;
  logic                cin;
  logic [RUN_W-1:0]    sum;
  logic [LIMB_W-1:0]   sub;
  logic [RUN_W-1:0]    wrap;

  assign in_act    = action_t'(s_tuser[1:0]);
  assign in_a      = s_tdata[LIMB_W-1:0];
  assign in_b      = s_tdata[WIDE_W-1:LIMB_W];
  assign in_a_over = (in_a > LIMB_MAX);
  assign in_b_over = (in_b > RUN_W'(LIMB_MAX));
  assign in_a_lim  = in_a_over ? LIMB_MAX : in_a;
  // first limb of a number starts from a clear running value
  assign in_run    = s_tuser[2] ? '0 : carry_register;
  assign accept    = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  // a stale nonzero running value counts as a carry or borrow of one
  assign b_lim = (b_raw > RUN_W'(LIMB_MAX)) ? LIMB_MAX : b_raw[LIMB_W-1:0];
  assign cin   = (run_w != '0);
  assign sum   = RUN_W'(a_lim) + RUN_W'(b_lim) + RUN_W'(cin);
  assign sub   = b_lim + LIMB_W'(cin);
  assign wrap  = RUN_W'(a_lim) + LIMB_BASE - RUN_W'(sub);

  b10k_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_act) inside
            ACT_ADD, ACT_SUB: state_next = S_ALU;
            ACT_DIV: begin
              if (in_b == '0) begin
                state_next = S_DONE;
              end else if (in_run >= in_b) begin
                state_next = S_RED_GO;
              end else begin
                state_next = S_SCALE;
              end
            end
            default: state_next = S_MUL;
          endcase
        end
      end
      S_ALU:      state_next = S_DONE;
      S_RED_GO:   state_next = S_RED_WAIT;
      S_RED_WAIT: if (div_rsp.done) state_next = S_SCALE;
      S_SCALE:    state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_rsp.done) state_next = S_DONE;
      S_MUL: begin
        if (cnt == STEPS_W'(MUL_STEPS - 1)) begin
          state_next = S_MDIV_GO;
        end
      end
      S_MDIV_GO:   state_next = S_MDIV_WAIT;
      S_MDIV_WAIT: if (div_rsp.done) state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready         = (state == S_IDLE);
    div_req.start    = (state == S_RED_GO) || (state == S_DIV_GO) || (state == S_MDIV_GO);
    // reduce a stale remainder first: its upper half is zero
    div_req.dividend = (state == S_RED_GO) ? WIDE_W'(run_w) : acc;
    div_req.divisor  = (state == S_MDIV_GO) ? LIMB_BASE : b_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      carry_register <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        carry_register <= run_w;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          act     <= in_act;
          a_lim   <= in_a_lim;
          b_raw   <= in_b;
          run_w   <= in_run;
          res_w   <= '0;
          // range fault only for add and subtract, divide by zero for divide
          fault_w <= (((in_act == ACT_ADD) || (in_act == ACT_SUB)) && (in_a_over || in_b_over))
                     || ((in_act == ACT_DIV) && (in_b == '0));
          acc     <= WIDE_W'(in_run);
          mcand   <= WIDE_W'(in_b);
          mplier  <= in_a_lim;
          cnt     <= '0;
        end
      end
      S_ALU: begin
        if (act == ACT_ADD) begin
          if (sum >= LIMB_BASE) begin
            res_w <= LIMB_W'(sum - LIMB_BASE);
            run_w <= RUN_W'(1);
          end else begin
            res_w <= sum[LIMB_W-1:0];
            run_w <= '0;
          end
        end else begin
          if (a_lim >= sub) begin
            res_w <= a_lim - sub;
            run_w <= '0;
          end else begin
            res_w <= wrap[LIMB_W-1:0];
            run_w <= RUN_W'(1);
          end
        end
      end
      S_RED_WAIT: begin
        if (div_rsp.done) begin
          run_w <= div_rsp.remainder;
        end
      end
      S_SCALE: begin
        // partial dividend: remainder * 10000 + limb
        acc <= WIDE_W'(run_w) * WIDE_W'(LIMB_BASE) + WIDE_W'(a_lim);
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_w <= div_rsp.quotient[LIMB_W-1:0];
          run_w <= div_rsp.remainder;
        end
      end
      S_MUL: begin
        // one multiplier bit per cycle, carry-in preloaded into acc
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[WIDE_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[LIMB_W-1:1]};
        cnt    <= cnt + 1'b1;
      end
      S_MDIV_WAIT: begin
        // product / 10000: quotient is the new carry, remainder the limb
        if (div_rsp.done) begin
          res_w <= div_rsp.remainder[LIMB_W-1:0];
          run_w <= div_rsp.quotient;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_res   <= res_w;
          out_run   <= run_w;
          out_fault <= fault_w;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {3'b000, out_run, out_res};
  assign m_tuser = out_fault;

endmodule

`default_nettype wire

### hw/rtl/b10k_div.sv
// ----------------------------------------------------------------------------
// b10k_div - bit-serial restoring divider
// 29-bit dividend by 15-bit divisor, one quotient bit per cycle; the upper
// dividend bits must already be below the divisor
// ----------------------------------------------------------------------------
`default_nettype none

module b10k_div
  import b10k_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [RUN_W-1:0]   rem;
  logic [RUN_W-1:0]   quo;
  logic [RUN_W-1:0]   dvs;
  logic [STEPS_W-1:0] cnt;
  logic               busy;
  logic               done;

  logic [RUN_W:0]     trial;
  logic [RUN_W+1:0]   diff;
  logic               fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quo[RUN_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~diff[RUN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEPS_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= RUN_W'(req.dividend[WIDE_W-1:RUN_W]);
      quo <= req.dividend[RUN_W-1:0];
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[RUN_W-1:0] : trial[RUN_W-1:0];
      quo <= {quo[RUN_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

### hw/rtl/b10k_checker.sv
// ----------------------------------------------------------------------------
// b10k_checker - port-level checks of the base-10000 limb unit
// watches the stream ports of the top level over time
// ----------------------------------------------------------------------------
`default_nettype none

module b10k_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("result pending or input closed after reset");

  // one item in flight: input closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // every result limb is a base-10000 digit
  a_limb_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:0] <= 14'd9999))
    else $error("result limb out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind base10000_limb_alu b10k_checker u_b10k_checker (.*);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench of base10000_limb_alu
// base-10000 limb streams for add, subtract, divide and multiply, a
// behavioural predictor with its own running value, and a checker that
// compares each result transaction field by field with the oldest
// expectation; sender gaps and receiver stalls change from phase to phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import b10k_pkg::*;

  // one input limb and the result it should produce
  typedef struct packed {
    action_t            action;
    logic [LIMB_W-1:0]  limb_a;
    logic [RUN_W-1:0]   operand_b;
    logic               first_limb;
  } limb_item_t;

  typedef struct packed {
    logic [LIMB_W-1:0] result_limb;
    logic [RUN_W-1:0]  running_value;
    logic              fault;
  } limb_result_t;

  localparam int RANDOM_PHASES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  // predictor copy of the carry register
  logic [RUN_W-1:0] held_run = '0;
  limb_result_t     pending_results[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int result_count  = 0;
  int fault_count   = 0;
  int action_count[4] = '{0, 0, 0, 0};

  base10000_limb_alu u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: one limb step, updates the held running value
  // --------------------------------------------------------------------------
  function automatic limb_result_t step_limb(limb_item_t it);
    int unsigned     a;
    int unsigned     b;
    int unsigned     run;
    int unsigned     acc;
    int unsigned     dividend;
    longint unsigned prod;
    limb_result_t    r;
    r = '0;
    a = 32'(it.limb_a);
    b = 32'(it.operand_b);
    if (it.first_limb) held_run = '0;
    run = 32'(held_run);
    case (it.action) inside
      ACT_ADD, ACT_SUB: begin
        // out-of-range operands are clamped and flagged
        if (a > LIMB_MAX) begin
          a = 32'(LIMB_MAX);
          r.fault = 1'b1;
        end
        if (b > LIMB_MAX) begin
          b = 32'(LIMB_MAX);
          r.fault = 1'b1;
        end
        if (it.action == ACT_ADD) begin
          // any stale nonzero value counts as a carry of one
          acc = a + b + ((run != 0) ? 1 : 0);
          if (acc >= LIMB_BASE) begin
            r.result_limb = LIMB_W'(acc - LIMB_BASE);
            run = 1;
          end else begin
            r.result_limb = LIMB_W'(acc);
            run = 0;
          end
        end else begin
          acc = b + ((run != 0) ? 1 : 0);
          if (a >= acc) begin
            r.result_limb = LIMB_W'(a - acc);
            run = 0;
          end else begin
            r.result_limb = LIMB_W'(a + LIMB_BASE - acc);
            run = 1;
          end
        end
      end
      ACT_DIV: begin
        if (a > LIMB_MAX) a = 32'(LIMB_MAX);
        if (b == 0) begin
          // divide by zero leaves the remainder alone
          r.fault = 1'b1;
          r.result_limb = '0;
        end else begin
          dividend = (run % b) * LIMB_BASE + a;
          r.result_limb = LIMB_W'(dividend / b);
          run = dividend % b;
        end
      end
      default: begin
        if (a > LIMB_MAX) a = 32'(LIMB_MAX);
        prod = longint'(a) * longint'(b) + longint'(run);
        r.result_limb = LIMB_W'(prod % LIMB_BASE);
        run = 32'(prod / LIMB_BASE);
      end
    endcase
    held_run = run[RUN_W-1:0];
    r.running_value = held_run;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // sender: one limb per transaction, random gaps before it
  // --------------------------------------------------------------------------
  task automatic send_limb(action_t act, logic [LIMB_W-1:0] a, logic [RUN_W-1:0] b,
                           logic first);
    limb_item_t it;
    it = '{act, a, b, first};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, b, a};
    s_tuser  <= {first, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(step_limb(it));
    action_count[act]++;
  endtask

  // receiver stalls at the phase's rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  // --------------------------------------------------------------------------
  // checker: every result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    limb_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (m_tuser[0]) fault_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result transaction with nothing outstanding: limb %0d run %0d",
                   m_tdata[13:0], m_tdata[28:14]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[13:0] !== want.result_limb)
          flag_mismatch("result_limb", want.result_limb, m_tdata[13:0]);
        if (m_tdata[28:14] !== want.running_value)
          flag_mismatch("running_value", want.running_value, m_tdata[28:14]);
        if (m_tuser[0] !== want.fault)
          flag_mismatch("fault", want.fault, m_tuser[0]);
      end
    end
  end

  // limb value biased towards the ends of the range
  function automatic logic [LIMB_W-1:0] pick_limb();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMB_MAX;
      default: return LIMB_W'($urandom_range(0, LIMB_MAX));
    endcase
  endfunction

  // small divisor or multiplier, now and then a large one
  function automatic logic [RUN_W-1:0] pick_factor();
    case ($urandom_range(0, 19)) inside
      0:       return RUN_W'(1);
      1:       return 15'h7fff;
      2, 3:    return RUN_W'($urandom_range(100, 32767));
      4:       return LIMB_BASE;
      default: return RUN_W'($urandom_range(2, 99));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // test tasks
  // --------------------------------------------------------------------------

  // extremes, every action, clamping, divide by zero and stale running values
  task automatic test_corner_cases();
    send_limb(ACT_ADD, 14'd0,     15'd0,     1'b1);
    send_limb(ACT_ADD, LIMB_MAX,  15'd9999,  1'b1);  // carry out
    send_limb(ACT_ADD, LIMB_MAX,  15'd0,     1'b0);  // carry ripples through
    send_limb(ACT_ADD, 14'd10000, 15'd32767, 1'b0);  // both operands clamped
    send_limb(ACT_ADD, 14'h3fff,  15'd1,     1'b1);  // limb_a clamped alone
    send_limb(ACT_SUB, 14'd0,     15'd0,     1'b1);
    send_limb(ACT_SUB, 14'd0,     15'd1,     1'b1);  // borrow out
    send_limb(ACT_SUB, 14'd0,     15'd9999,  1'b0);  // borrow in and out
    send_limb(ACT_SUB, 14'h3fff,  15'h7fff,  1'b0);  // both clamped
    send_limb(ACT_SUB, 14'd5,     15'd10000, 1'b1);  // operand_b clamped alone
    send_limb(ACT_DIV, LIMB_MAX,  15'd7,     1'b1);
    send_limb(ACT_DIV, 14'd1234,  15'd7,     1'b0);
    send_limb(ACT_DIV, 14'd4321,  15'd0,     1'b0);  // divide by zero keeps remainder
    send_limb(ACT_DIV, 14'd100,   15'd7,     1'b0);
    send_limb(ACT_DIV, 14'd100,   15'd0,     1'b1);  // divide by zero on first limb
    send_limb(ACT_DIV, 14'h3fff,  15'h7fff,  1'b1);  // limb clamped without fault
    send_limb(ACT_MUL, LIMB_MAX,  15'h7fff,  1'b1);  // largest operands
    send_limb(ACT_MUL, LIMB_MAX,  15'h7fff,  1'b0);
    send_limb(ACT_DIV, 14'd17,    15'd3,     1'b0);  // stale carry above divisor
    send_limb(ACT_MUL, 14'h3fff,  15'd1,     1'b1);  // limb clamped without fault
    send_limb(ACT_MUL, 14'd5000,  15'd9,     1'b0);
    send_limb(ACT_ADD, 14'd1,     15'd1,     1'b0);  // stale product carry as carry
    send_limb(ACT_MUL, 14'd9000,  15'd20,    1'b1);
    send_limb(ACT_SUB, 14'd9,     15'd1,     1'b0);  // stale product carry as borrow
    send_limb(ACT_MUL, 14'd0,     15'd0,     1'b0);
  endtask

  // long additions, least significant limb first
  task automatic test_add_numbers(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_limb(ACT_ADD, pick_limb(), RUN_W'(pick_limb()), i == 0);
      sent += len;
    end
  endtask

  // long subtractions, often with borrows running through
  task automatic test_sub_numbers(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_limb(ACT_SUB, pick_limb(), RUN_W'(pick_limb()), i == 0);
      sent += len;
    end
  endtask

  // long division by a small number, most significant limb first
  task automatic test_div_numbers(int n_items);
    int               sent;
    int               len;
    logic [RUN_W-1:0] divisor;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      divisor = ($urandom_range(0, 29) == 0) ? '0 : pick_factor();
      for (int i = 0; i < len; i++)
        send_limb(ACT_DIV, pick_limb(), divisor, i == 0);
      sent += len;
    end
  endtask

  // long multiplication by a small number, least significant limb first
  task automatic test_mul_numbers(int n_items);
    int               sent;
    int               len;
    logic [RUN_W-1:0] factor;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      factor = ($urandom_range(0, 29) == 0) ? '0 : pick_factor();
      for (int i = 0; i < len; i++)
        send_limb(ACT_MUL, pick_limb(), factor, i == 0);
      sent += len;
    end
  endtask

  // unstructured traffic: any action, any field value, broken numbers
  task automatic test_random_noise(int n_items);
    for (int i = 0; i < n_items; i++)
      send_limb(action_t'($urandom_range(0, 3)), LIMB_W'($urandom_range(0, 16383)),
                RUN_W'($urandom_range(0, 32767)), $urandom_range(0, 3) == 0);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_cases();

    // idling phases: none, sender gaps, receiver stalls, light on both sides
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 55; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      test_add_numbers(110);
      test_sub_numbers(110);
      test_div_numbers(110);
      test_mul_numbers(110);
      test_random_noise(40);
    end
    s_tvalid <= 1'b0;
    stall_pct = 0;

    // drain, then give the block time to show any stray transaction
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d add, %0d subtract, %0d divide and %0d multiply limbs",
             action_count[ACT_ADD], action_count[ACT_SUB], action_count[ACT_DIV],
             action_count[ACT_MUL]);
    $display("%0d results checked, %0d with fault set, %0d mismatches",
             result_count, fault_count, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
